[sv/ffha_pkg.sv]
package ffha_pkg;

	localparam int unsigned HEAP_BYTES_DEF = 65536;
	localparam int unsigned GRANULE_BYTES = 8;
	localparam int unsigned HEADER_BYTES = 8;
	localparam int unsigned SPLIT_SLACK = 2;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned REQ_W = 17;
	// Granule count a heap-sized request needs: (65536 + 8 + 7) / 8 = 8193.
	localparam int unsigned NEED_W = 14;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_READ_CUR,
		OP_ADV,
		OP_WR_REM,
		OP_WR_IDX,
		OP_UNLINK,
		OP_BUMP,
		OP_READ_FREE,
		OP_WR_FREE,
		OP_RESP
	} dp_op_t;

	typedef enum logic [1:0] {
		RES_FAIL,
		RES_GRANT,
		RES_FREE
	} res_t;

	typedef struct packed {
		dp_op_t op;
		res_t   res;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic free_ok;
		logic zero_req;
		logic walk_end;
		logic fit;
		logic split;
		logic bump_ok;
		logic out_full;
	} dp_sts_t;

endpackage

[sv/ffha_ram.sv]
module ffha_ram #(
	parameter int unsigned W = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/ffha_ctrl.sv]
module ffha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ffha_pkg::dp_sts_t sts,
	output ffha_pkg::dp_cmd_t cmd
);

	import ffha_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_WALK,
		S_CHECK,
		S_SPL1,
		S_SPL2,
		S_UNLINK,
		S_BUMP,
		S_FREE_WR,
		S_RESP
	} state_t;

	state_t state_q;
	res_t   res_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op = OP_NONE;
		cmd.res = res_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_DECIDE: begin
				if (sts.is_free && sts.free_ok) cmd.op = OP_READ_FREE;
			end
			S_WALK: begin
				if (!sts.walk_end) cmd.op = OP_READ_CUR;
			end
			S_CHECK: begin
				if (!sts.fit) cmd.op = OP_ADV;
			end
			S_SPL1: cmd.op = OP_WR_REM;
			S_SPL2: cmd.op = OP_WR_IDX;
			S_UNLINK: cmd.op = OP_UNLINK;
			S_BUMP: begin
				if (sts.bump_ok) cmd.op = OP_BUMP;
			end
			S_FREE_WR: cmd.op = OP_WR_FREE;
			S_RESP: begin
				if (!sts.out_full) cmd.op = OP_RESP;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q <= RES_FAIL;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (sts.is_free) begin
						if (sts.free_ok) begin
							state_q <= S_FREE_WR;
						end else begin
							res_q <= RES_FAIL;
							state_q <= S_RESP;
						end
					end else if (sts.zero_req) begin
						res_q <= RES_FAIL;
						state_q <= S_RESP;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					state_q <= sts.walk_end ? S_BUMP : S_CHECK;
				end
				S_CHECK: begin
					if (sts.fit) state_q <= sts.split ? S_SPL1 : S_UNLINK;
					else state_q <= S_WALK;
				end
				S_SPL1: state_q <= S_SPL2;
				S_SPL2: state_q <= S_UNLINK;
				S_UNLINK: begin
					res_q <= RES_GRANT;
					state_q <= S_RESP;
				end
				S_BUMP: begin
					res_q <= sts.bump_ok ? RES_GRANT : RES_FAIL;
					state_q <= S_RESP;
				end
				S_FREE_WR: begin
					res_q <= RES_FREE;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!sts.out_full) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The header compare needs the data of the read issued in the previous cycle.
	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> ($past(cmd.op) == OP_READ_CUR))
		else $error("header check without a preceding read");

	a_resp_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_RESP) |-> !sts.out_full)
		else $error("result written over a waiting result");

endmodule

[sv/ffha_dp.sv]
module ffha_dp #(
	parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [ffha_pkg::ADDR_W-1:0]   cfg_write_data,
	input  logic                          kind,
	input  logic [ffha_pkg::REQ_W-1:0]    request_bytes,
	input  logic [ffha_pkg::ADDR_W-1:0]   freed_address,
	input  logic                          out_ready,
	input  ffha_pkg::dp_cmd_t             cmd,
	output ffha_pkg::dp_sts_t             sts,
	output logic                          out_valid,
	output logic [ffha_pkg::ADDR_W-1:0]   granted_address,
	output logic                          accepted,
	output logic [ffha_pkg::ADDR_W-1:0]   allocations_done,
	output logic [ffha_pkg::ADDR_W-1:0]   frees_done
);

	import ffha_pkg::*;

	localparam int unsigned SLOTS = HEAP_BYTES / GRANULE_BYTES;
	localparam int unsigned IX_W = $clog2(SLOTS);
	localparam int unsigned LK_W = $clog2(SLOTS + 1);
	localparam int unsigned CW = ((LK_W > NEED_W) ? LK_W : NEED_W) + 1;

	logic [ADDR_W-1:0] start_q;
	logic              is_free_q, zero_q, free_ok_q;
	logic [NEED_W-1:0] need_q;
	logic [IX_W-1:0]   fidx_q, slot_q;
	logic [LK_W-1:0]   cur_q, prev_q, prev_size_q, steps_q, head_q, top_q;
	logic [ADDR_W-1:0] ac_q, fc_q;
	logic              out_valid_q;

	logic              ram_we, ram_re;
	logic [IX_W-1:0]   ram_waddr, ram_raddr;
	logic [2*LK_W-1:0] ram_wdata, ram_rdata;

	logic [REQ_W:0]    need_sum;
	logic [ADDR_W-1:0] off;
	logic [LK_W-1:0]   cur_m1, prev_m1, rd_size, rd_link, rem_lk, new_link;
	logic [IX_W-1:0]   idx, rem;
	logic [CW-1:0]     size_c, need_c, rem_sum, size_left;

	assign need_sum = {1'b0, request_bytes} + (REQ_W+1)'(HEADER_BYTES + GRANULE_BYTES - 1);
	assign off = freed_address - ADDR_W'(HEADER_BYTES) - start_q;

	assign cur_m1 = cur_q - LK_W'(1);
	assign prev_m1 = prev_q - LK_W'(1);
	assign idx = cur_m1[IX_W-1:0];
	assign rd_size = ram_rdata[2*LK_W-1:LK_W];
	assign rd_link = ram_rdata[LK_W-1:0];
	assign size_c = CW'(rd_size);
	assign need_c = CW'(need_q);
	assign size_left = size_c - need_c;
	assign rem_sum = CW'(idx) + need_c;
	assign rem = rem_sum[IX_W-1:0];
	assign rem_lk = LK_W'(rem) + LK_W'(1);
	assign new_link = sts.split ? rem_lk : rd_link;

	always_comb begin
		sts.is_free = is_free_q;
		sts.free_ok = free_ok_q;
		sts.zero_req = zero_q;
		sts.walk_end = (cur_q == '0) || (steps_q == LK_W'(SLOTS));
		sts.fit = (size_c >= need_c);
		sts.split = (size_c > need_c + CW'(SPLIT_SLACK)) && (need_c < CW'(SLOTS) - CW'(idx));
		sts.bump_ok = (need_c <= CW'(SLOTS) - CW'(top_q));
		sts.out_full = out_valid_q;
	end

	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = '0;
		ram_raddr = '0;
		ram_wdata = '0;
		case (cmd.op)
			OP_READ_CUR: begin
				ram_re = 1'b1;
				ram_raddr = idx;
			end
			OP_WR_REM: begin
				ram_we = 1'b1;
				ram_waddr = rem;
				ram_wdata = {size_left[LK_W-1:0], rd_link};
			end
			OP_WR_IDX: begin
				ram_we = 1'b1;
				ram_waddr = idx;
				ram_wdata = {need_c[LK_W-1:0], rem_lk};
			end
			OP_UNLINK: begin
				// The predecessor keeps its size; only its link moves past the taken block.
				if (prev_q != '0) begin
					ram_we = 1'b1;
					ram_waddr = prev_m1[IX_W-1:0];
					ram_wdata = {prev_size_q, new_link};
				end
			end
			OP_BUMP: begin
				ram_we = 1'b1;
				ram_waddr = top_q[IX_W-1:0];
				ram_wdata = {need_c[LK_W-1:0], LK_W'(0)};
			end
			OP_READ_FREE: begin
				ram_re = 1'b1;
				ram_raddr = fidx_q;
			end
			OP_WR_FREE: begin
				ram_we = 1'b1;
				ram_waddr = fidx_q;
				ram_wdata = {rd_size, head_q};
			end
			default: ram_we = 1'b0;
		endcase
	end

	ffha_ram #(.W(2 * LK_W), .DEPTH(SLOTS)) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			head_q <= '0;
			top_q <= '0;
			ac_q <= '0;
			fc_q <= '0;
			steps_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) start_q <= cfg_write_data;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_LOAD: steps_q <= '0;
				OP_ADV: steps_q <= steps_q + LK_W'(1);
				OP_UNLINK: begin
					if (prev_q == '0) head_q <= new_link;
				end
				OP_BUMP: top_q <= top_q + need_c[LK_W-1:0];
				OP_WR_FREE: head_q <= LK_W'(fidx_q) + LK_W'(1);
				OP_RESP: begin
					out_valid_q <= 1'b1;
					if (cmd.res == RES_GRANT) ac_q <= ac_q + ADDR_W'(1);
					if (cmd.res == RES_FREE) fc_q <= fc_q + ADDR_W'(1);
				end
				default: steps_q <= steps_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				is_free_q <= kind;
				zero_q <= (request_bytes == '0);
				need_q <= need_sum[NEED_W+2:3];
				free_ok_q <= (freed_address != '0) && (off < ADDR_W'(HEAP_BYTES))
					&& (off[2:0] == 3'b000);
				fidx_q <= off[IX_W+2:3];
				cur_q <= head_q;
				prev_q <= '0;
			end
			OP_ADV: begin
				prev_q <= cur_q;
				prev_size_q <= rd_size;
				cur_q <= rd_link;
			end
			OP_UNLINK: slot_q <= idx;
			OP_BUMP: slot_q <= top_q[IX_W-1:0];
			OP_RESP: begin
				case (cmd.res)
					RES_GRANT: begin
						granted_address <= start_q + ADDR_W'({slot_q, 3'b000})
							+ ADDR_W'(HEADER_BYTES);
						accepted <= 1'b1;
						allocations_done <= ac_q + ADDR_W'(1);
						frees_done <= fc_q;
					end
					RES_FREE: begin
						granted_address <= '0;
						accepted <= 1'b1;
						allocations_done <= ac_q;
						frees_done <= fc_q + ADDR_W'(1);
					end
					default: begin
						granted_address <= '0;
						accepted <= 1'b0;
						allocations_done <= ac_q;
						frees_done <= fc_q;
					end
				endcase
			end
			default: cur_q <= cur_q;
		endcase
	end

	assign out_valid = out_valid_q;

	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("header store read and written in one cycle");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= LK_W'(SLOTS))
		else $error("free-list walk ran past the slot count");

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= LK_W'(SLOTS))
		else $error("bump top beyond the heap");

endmodule

[sv/first_fit_heap_allocator_top.sv]
// First-fit heap allocator. Each item is an allocate or a free; each gives one result item.
// Block headers (size and link) live in a RAM of one entry per 8-byte slot, and each access
// to it takes a state of its own. A zero request or an ignored free goes from the decision
// straight to the result. An accepted free reads the freed block's header and writes it back
// at the head of the free list. An allocation reads and checks the free-list blocks in turn.
// On a fit it writes the remainder and the taken header if the block is split, then unlinks
// it; when the walk ends, after at most the slot count of blocks, it takes from the bump
// region. A result that is still waiting on the output holds the block in its last state
// until it is taken. The heap start register may only be written while no item is in flight.
module first_fit_heap_allocator_top #(
	parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [ffha_pkg::ADDR_W-1:0]   cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [ffha_pkg::REQ_W-1:0]    request_bytes,
	input  logic [ffha_pkg::ADDR_W-1:0]   freed_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ffha_pkg::ADDR_W-1:0]   granted_address,
	output logic                          accepted,
	output logic [ffha_pkg::ADDR_W-1:0]   allocations_done,
	output logic [ffha_pkg::ADDR_W-1:0]   frees_done
);

	import ffha_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffha_dp #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_en     (cfg_write_en),
		.cfg_write_data   (cfg_write_data),
		.kind             (kind),
		.request_bytes    (request_bytes),
		.freed_address    (freed_address),
		.out_ready        (out_ready),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (out_valid),
		.granted_address  (granted_address),
		.accepted         (accepted),
		.allocations_done (allocations_done),
		.frees_done       (frees_done)
	);

endmodule

[test/tb_first_fit_heap_allocator_top.sv]
module tb_first_fit_heap_allocator_top;
	import ffha_pkg::*;

	localparam int unsigned SLOTS = HEAP_BYTES_DEF / GRANULE_BYTES;
	localparam bit KIND_ALLOC = 1'b0;
	localparam bit KIND_FREE = 1'b1;

	typedef struct {
		logic [ADDR_W-1:0] granted;
		logic              ok;
		logic [ADDR_W-1:0] allocs;
		logic [ADDR_W-1:0] frees;
	} alloc_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_write_en;
	logic [ADDR_W-1:0] cfg_write_data;
	logic              in_valid;
	logic              in_ready;
	logic              kind;
	logic [REQ_W-1:0]  request_bytes;
	logic [ADDR_W-1:0] freed_address;
	logic              out_valid;
	logic              out_ready;
	logic [ADDR_W-1:0] granted_address;
	logic              accepted;
	logic [ADDR_W-1:0] allocations_done;
	logic [ADDR_W-1:0] frees_done;

	first_fit_heap_allocator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .request_bytes(request_bytes), .freed_address(freed_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.granted_address(granted_address), .accepted(accepted),
		.allocations_done(allocations_done), .frees_done(frees_done)
	);

	// Shadow allocator state.
	int unsigned hdr_size [SLOTS];
	int unsigned hdr_link [SLOTS];
	int unsigned free_head;
	int unsigned bump_top;
	logic [ADDR_W-1:0] alloc_count;
	logic [ADDR_W-1:0] free_count;
	logic [ADDR_W-1:0] heap_start;
	bit last_ok;
	int unsigned last_slot;

	alloc_result_t pending_results[$];
	int unsigned live_slots[$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int grants_seen = 0;
	int configs_written = 0;
	bit no_idle = 0;
	int rx_hold = 0;
	int rx_wait = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("== FAIL ==");
		$finish;
	end

	function automatic bit first_fit(int unsigned need, output int unsigned slot);
		int unsigned prev;
		int unsigned cur;
		int unsigned steps;
		int unsigned idx;
		int unsigned sz;
		int unsigned rem;
		prev = 0;
		cur = free_head;
		steps = 0;
		slot = 0;
		while (cur != 0 && steps < SLOTS) begin
			idx = cur - 1;
			if (idx >= SLOTS)
				return 0;
			if (hdr_size[idx] >= need) begin
				sz = hdr_size[idx];
				if (sz > need + SPLIT_SLACK && need < SLOTS - idx) begin
					rem = idx + need;
					hdr_size[rem] = sz - need;
					hdr_link[rem] = hdr_link[idx];
					hdr_size[idx] = need;
					hdr_link[idx] = rem + 1;
				end
				if (prev == 0)
					free_head = hdr_link[idx];
				else
					hdr_link[prev - 1] = hdr_link[idx];
				slot = idx;
				return 1;
			end
			prev = cur;
			cur = hdr_link[idx];
			steps++;
		end
		return 0;
	endfunction

	function automatic bit bump_take(int unsigned need, output int unsigned slot);
		int unsigned nbytes;
		nbytes = need * GRANULE_BYTES;
		slot = 0;
		if (bump_top > HEAP_BYTES_DEF || nbytes > HEAP_BYTES_DEF - bump_top)
			return 0;
		slot = bump_top / GRANULE_BYTES;
		if (slot >= SLOTS)
			return 0;
		hdr_size[slot] = need;
		hdr_link[slot] = 0;
		bump_top += nbytes;
		return 1;
	endfunction

	// Applies one accepted item to the shadow state and queues its result.
	function automatic void predict_allocation(bit k, logic [REQ_W-1:0] req,
			logic [ADDR_W-1:0] fa);
		alloc_result_t r;
		int unsigned need;
		int unsigned slot;
		logic [ADDR_W-1:0] off;
		r.granted = '0;
		r.ok = 0;
		last_ok = 0;
		if (k == KIND_ALLOC) begin
			if (req != 0) begin
				need = (int'(req) + HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
				if (first_fit(need, slot) || bump_take(need, slot)) begin
					r.granted = heap_start + slot * GRANULE_BYTES + HEADER_BYTES;
					r.ok = 1;
					alloc_count++;
					last_slot = slot;
				end
			end
		end else if (fa != 0) begin
			off = (fa - HEADER_BYTES) - heap_start;
			if (off < HEAP_BYTES_DEF && off[2:0] == 3'd0) begin
				slot = off / GRANULE_BYTES;
				hdr_link[slot] = free_head;
				free_head = slot + 1;
				free_count++;
				r.ok = 1;
			end
		end
		last_ok = r.ok;
		r.allocs = alloc_count;
		r.frees = free_count;
		pending_results.push_back(r);
	endfunction

	task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
			logic [ADDR_W-1:0] want);
		errors++;
		$display("Mismatch on %s at result %0d: got %h, expected %h",
			what, results_seen, got, want);
	endtask

	always @(posedge clk) begin
		alloc_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("Result item with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (granted_address !== want.granted)
					report_mismatch("granted_address", granted_address, want.granted);
				if (accepted !== want.ok)
					report_mismatch("accepted", ADDR_W'(accepted), ADDR_W'(want.ok));
				if (allocations_done !== want.allocs)
					report_mismatch("allocations_done", allocations_done, want.allocs);
				if (frees_done !== want.frees)
					report_mismatch("frees_done", frees_done, want.frees);
				if (want.ok && want.granted != 0)
					grants_seen++;
			end
			results_seen++;
			rx_wait = no_idle ? 0 : $urandom_range(0, 3);
		end
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else if (rx_wait > 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else
			out_ready <= 1'b1;
	end

	task automatic send_item(bit k, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] fa);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		request_bytes <= req;
		freed_address <= fa;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_allocation(k, req, fa);
		items_sent++;
		if (k == KIND_ALLOC && last_ok)
			live_slots.push_back(last_slot);
	endtask

	function automatic logic [ADDR_W-1:0] slot_pointer(int unsigned slot);
		return heap_start + slot * GRANULE_BYTES + HEADER_BYTES;
	endfunction

	task automatic alloc_bytes(int unsigned n);
		send_item(KIND_ALLOC, REQ_W'(n), $urandom);
	endtask

	task automatic free_junk(logic [ADDR_W-1:0] fa);
		send_item(KIND_FREE, REQ_W'($urandom), fa);
	endtask

	// Frees the live block at position pos of the live list.
	task automatic free_live(int pos);
		int unsigned slot;
		slot = live_slots[pos];
		free_junk(slot_pointer(slot));
		if (last_ok)
			live_slots.delete(pos);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_heap_start(logic [ADDR_W-1:0] value);
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		heap_start = value;
		configs_written++;
		@(posedge clk);
	endtask

	task automatic test_directed();
		int unsigned s;
		write_heap_start(32'h0000_0000);
		alloc_bytes(1);
		alloc_bytes(8);
		alloc_bytes(9);
		alloc_bytes(0);
		alloc_bytes(65536);
		free_junk('0);
		free_junk(slot_pointer(live_slots[1]) + 4);
		free_junk(heap_start + 32'h0002_0000);
		free_junk(heap_start);
		alloc_bytes(100);
		free_live(3);
		// A 14-granule block serving a 3-granule request gets split.
		alloc_bytes(16);
		alloc_bytes(40);
		// Larger than the remaining free block, so it comes from the bump region.
		alloc_bytes(56);
		free_live(0);
		wait_drained();
		// Slot 0 now heads the list; with this start its pointer wraps to zero.
		write_heap_start(32'hFFFF_FFF8);
		alloc_bytes(1);
		s = live_slots[live_slots.size() - 1];
		free_junk(slot_pointer(s));
		alloc_bytes(65535);
		wait_drained();
	endtask

	task automatic random_item();
		int r;
		int unsigned n;
		int pos;
		r = $urandom_range(0, 99);
		if (live_slots.size() > 80 && r < 45)
			r = 60;
		if (live_slots.size() == 0 && r >= 45 && r < 85)
			r = 0;
		if (r < 45) begin
			n = $urandom_range(0, 99);
			if (n < 70)
				n = $urandom_range(1, 64);
			else if (n < 95)
				n = $urandom_range(65, 2048);
			else
				n = $urandom_range(2049, 65536);
			alloc_bytes(n);
		end else if (r < 85)
			free_live($urandom_range(0, live_slots.size() - 1));
		else if (r < 89)
			alloc_bytes(0);
		else if (r < 92)
			free_junk('0);
		else if (r < 95)
			free_junk(heap_start + HEADER_BYTES + HEAP_BYTES_DEF
				+ $urandom_range(0, 32'hFFFE_0000));
		else if (r < 98 && live_slots.size() != 0) begin
			pos = $urandom_range(0, live_slots.size() - 1);
			free_junk(slot_pointer(live_slots[pos]) + $urandom_range(1, 7));
		end else
			alloc_bytes($urandom_range(60000, 65536));
	endtask

	task automatic test_random_mix();
		logic [ADDR_W-1:0] starts [5];
		starts[0] = 32'h1234_5000;
		starts[1] = 32'hFFFF_F000;
		starts[2] = 32'h0000_0007;
		starts[3] = 32'h8000_0000;
		starts[4] = 32'h0000_0000;
		for (int ph = 0; ph < 5; ph++) begin
			write_heap_start(starts[ph]);
			for (int i = 0; i < 260; i++) begin
				no_idle = (i >= 100 && i < 150);
				random_item();
			end
			no_idle = 0;
			wait_drained();
		end
	endtask

	task automatic test_heap_exhaustion();
		for (int i = 0; i < 24; i++)
			alloc_bytes(4096);
		for (int i = 0; i < 12 && live_slots.size() != 0; i++)
			free_live($urandom_range(0, live_slots.size() - 1));
		for (int i = 0; i < 150; i++)
			random_item();
		wait_drained();
	endtask

	task automatic test_backpressure();
		rx_hold = 400;
		no_idle = 1;
		for (int i = 0; i < 30; i++)
			random_item();
		no_idle = 0;
		for (int i = 0; i < 40; i++)
			random_item();
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 10; i++)
			random_item();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 10; i++)
			random_item();
		wait_drained();
	endtask

	// A double free puts a loop in the list; walks then run out at the slot count.
	task automatic test_double_free();
		int unsigned s;
		alloc_bytes(24);
		s = live_slots[live_slots.size() - 1];
		free_junk(slot_pointer(s));
		free_junk(slot_pointer(s));
		alloc_bytes(65536);
		alloc_bytes(3000);
		alloc_bytes(16);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		in_valid = 1'b0;
		kind = 1'b0;
		request_bytes = '0;
		freed_address = '0;
		out_ready = 1'b0;
		free_head = 0;
		bump_top = 0;
		alloc_count = '0;
		free_count = '0;
		heap_start = '0;
		for (int i = 0; i < SLOTS; i++) begin
			hdr_size[i] = 0;
			hdr_link[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix();
		test_heap_exhaustion();
		test_backpressure();
		test_drain_pause();
		test_double_free();

		$display("Sent %0d items over %0d heap start settings; %0d results checked.",
			items_sent, configs_written, results_seen);
		$display("Covered splits, heap exhaustion, bad and null frees, a double free "
			, "and %0d nonzero grants.", grants_seen);
		if (errors == 0)
			$display("== PASS ==");
		else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
